@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the core checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Consequent holds in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle check that also runs through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check across reset failed");

`endif

@@ rtl/emb_pkg.sv @@
// ---------------------------------------------------------------------------
// Emboss filter package
// Sizes, register codes, queue item type and the fixed emboss kernel.
// ---------------------------------------------------------------------------
package emb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int COORD_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int IDX_W      = 20;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 12;
  localparam int Q_DEPTH    = 8;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic             centre;
    logic             border;
    logic [IDX_W-1:0] centre_index;
    logic [IDX_W-1:0] border_index;
    logic [PIX_W-1:0] filtered;
    logic [PIX_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (r == '0) r = DIM_W'(1);
    if (r > maxv) r = maxv;
    return r;
  endfunction

  // kernel -2 -1 0 / -1 1 1 / 0 1 2, clamped to 0..255
  function automatic logic [PIX_W-1:0] emboss(input window_t w);
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] neg;
    logic [SUM_W-1:0] d;
    logic [PIX_W-1:0] r;
    pos = SUM_W'(w[4]) + SUM_W'(w[5]) + SUM_W'(w[7]) + (SUM_W'(w[8]) << 1);
    neg = (SUM_W'(w[0]) << 1) + SUM_W'(w[1]) + SUM_W'(w[3]);
    d   = pos - neg;
    if (pos <= neg) r = '0;
    else if (d > SUM_W'(255)) r = '1;
    else r = d[PIX_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/emb_pix_if.sv @@
// ---------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one grayscale pixel per beat.
// ---------------------------------------------------------------------------
interface emb_pix_if import emb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

@@ rtl/emb_res_if.sv @@
// ---------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one index/value result per beat.
// ---------------------------------------------------------------------------
interface emb_res_if import emb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [PIX_W-1:0] filtered_value;
  logic             last_of_run;

  modport source (output valid, output pixel_index, output filtered_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input pixel_index, input filtered_value,
                  input last_of_run, output ready);
endinterface

@@ rtl/emb_front.sv @@
// ---------------------------------------------------------------------------
// Emboss front end
// Accepts pixels, tracks raster position, classifies border and centre,
// keeps the line buffers and the 3x3 window, and computes the emboss value.
// ---------------------------------------------------------------------------
module emb_front import emb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  emb_pix_if.sink              pix,
  input  logic [Q_CNT_W-1:0]   q_count,
  output push_t                push
);

  logic [DIM_W-1:0]   width;
  logic [DIM_W-1:0]   height;
  logic [COORD_W-1:0] col;
  logic [ROW_W-1:0]   row;
  logic [IDX_W-1:0]   index;

  logic [2*PIX_W-1:0] lbuf [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata;

  logic               a_valid;
  logic [PIX_W-1:0]   a_px;
  logic               a_border;
  logic               a_centre;
  logic [IDX_W-1:0]   a_cidx;
  logic [IDX_W-1:0]   a_bidx;
  logic [COORD_W-1:0] a_addr;

  logic               b_valid;
  logic [PIX_W-1:0]   b_px;
  logic               b_border;
  logic               b_centre;
  logic [IDX_W-1:0]   b_cidx;
  logic [IDX_W-1:0]   b_bidx;
  window_t            window;

  logic               acc;
  logic               col_last;
  logic               row_last;
  logic               border;
  logic               centre;
  logic [Q_CNT_W-1:0] inflight;

  assign inflight  = q_count + Q_CNT_W'(a_valid) + Q_CNT_W'(b_valid);
  assign pix.ready = (inflight < Q_CNT_W'(Q_DEPTH)) && !rst;
  assign acc       = pix.valid && pix.ready;

  assign col_last = (DIM_W'(col) + DIM_W'(1)) == width;
  assign row_last = (DIM_W'(row) + DIM_W'(1)) == height;
  assign border   = (row == '0) || (col == '0) || row_last || col_last;
  assign centre   = (row >= ROW_W'(2)) && (col >= COORD_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= DIM_W'(MAX_WIDTH);
      height <= DIM_W'(MAX_HEIGHT);
      col    <= '0;
      row    <= '0;
      index  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
        REG_IMAGE_HEIGHT: height <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
      col   <= '0;
      row   <= '0;
      index <= '0;
    end else if (acc) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row   <= '0;
          index <= '0;
        end else begin
          row   <= row + ROW_W'(1);
          index <= index + IDX_W'(1);
        end
      end else begin
        col   <= col + COORD_W'(1);
        index <= index + IDX_W'(1);
      end
    end
  end

  // line buffers: read at accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (acc) rdata <= lbuf[col];
    if (a_valid) lbuf[a_addr] <= {rdata[PIX_W-1:0], a_px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= acc;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_px     <= pix.pixel_value;
      a_border <= border;
      a_centre <= centre;
      a_cidx   <= index - IDX_W'(width) - IDX_W'(1);
      a_bidx   <= index;
      a_addr   <= col;
    end
    if (a_valid) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= rdata[2*PIX_W-1:PIX_W];
      window[3] <= window[4];
      window[4] <= window[5];
      window[5] <= rdata[PIX_W-1:0];
      window[6] <= window[7];
      window[7] <= window[8];
      window[8] <= a_px;
      b_px      <= a_px;
      b_border  <= a_border;
      b_centre  <= a_centre;
      b_cidx    <= a_cidx;
      b_bidx    <= a_bidx;
    end
  end

  always_comb begin
    push.valid             = b_valid && (b_centre || b_border);
    push.item.centre       = b_centre;
    push.item.border       = b_border;
    push.item.centre_index = b_cidx;
    push.item.border_index = b_bidx;
    push.item.filtered     = emboss(window);
    push.item.pixel        = b_px;
  end

endmodule

@@ rtl/emb_queue.sv @@
// ---------------------------------------------------------------------------
// Emboss item queue
// Short FIFO of classified items between the front end and the back end.
// ---------------------------------------------------------------------------
module emb_queue import emb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  input  logic               pop,
  output logic               q_valid,
  output item_t              q_item,
  output logic [Q_CNT_W-1:0] q_count
);

  item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic               do_pop;

  assign q_valid = q_count != '0;
  assign q_item  = slots[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + Q_PTR_W'(1);
      q_count <= q_count + Q_CNT_W'(push.valid) - Q_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) slots[wr_ptr] <= push.item;
  end

endmodule

@@ rtl/emb_back.sv @@
// ---------------------------------------------------------------------------
// Emboss back end
// Expands each queued item into one or two result beats in index order.
// ---------------------------------------------------------------------------
module emb_back import emb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  emb_res_if.source  res
);

  logic             pending;
  logic [IDX_W-1:0] pend_index;
  logic [PIX_W-1:0] pend_pixel;
  logic             can_load;

  assign can_load = !res.valid || res.ready;
  assign q_pop    = can_load && !pending && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      pending   <= 1'b0;
    end else if (can_load) begin
      if (pending) begin
        res.valid <= 1'b1;
        pending   <= 1'b0;
      end else if (q_valid) begin
        res.valid <= 1'b1;
        pending   <= q_item.centre && q_item.border;
      end else begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pending) begin
        res.pixel_index    <= pend_index;
        res.filtered_value <= pend_pixel;
        res.last_of_run    <= 1'b1;
      end else if (q_valid) begin
        pend_index <= q_item.border_index;
        pend_pixel <= q_item.pixel;
        if (q_item.centre) begin
          res.pixel_index    <= q_item.centre_index;
          res.filtered_value <= q_item.filtered;
          res.last_of_run    <= !q_item.border;
        end else begin
          res.pixel_index    <= q_item.border_index;
          res.filtered_value <= q_item.pixel;
          res.last_of_run    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/emboss_convolution_3x3_core.sv @@
// Path: an accepted pixel passes stage a, stage b, the queue and the back-end result register.
// Throughput: one pixel per clock while the queue has room; a pixel that yields two results holds the
// output for both of its beats in turn, since the back end has a single result register.
// Reset: synchronous; position counters and queue clear, width and height return to
// 1024; line buffers and window are not cleared.
// ---------------------------------------------------------------------------
// Emboss 3x3 convolution core
// Raster pixel stream in, index/value result stream out, border pass-through.
// ---------------------------------------------------------------------------
module emboss_convolution_3x3_core import emb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  emb_pix_if.sink              pix,
  emb_res_if.source            res
);

  push_t              push;
  logic               q_pop;
  logic               q_valid;
  item_t              q_item;
  logic [Q_CNT_W-1:0] q_count;

  emb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .q_count   (q_count),
    .push      (push)
  );

  emb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_count (q_count)
  );

  emb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

@@ rtl/emb_checker.sv @@
// ---------------------------------------------------------------------------
// Emboss core checker
// Port-level checks on the result channel, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module emb_checker import emb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic [IDX_W-1:0] res_pixel_index,
  input logic [PIX_W-1:0] res_filtered_value,
  input logic             res_last_of_run
);

  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !res_valid)
  `ASSERT_NEXT(a_hold_valid, clk, rst, res_valid && !res_ready, res_valid)
  `ASSERT_NEXT(a_hold_data, clk, rst, res_valid && !res_ready, $stable(res_pixel_index) && $stable(res_filtered_value) && $stable(res_last_of_run))
  `ASSERT_NEXT(a_run_follows, clk, rst, res_valid && res_ready && !res_last_of_run, res_valid)

endmodule

bind emboss_convolution_3x3_core emb_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_pixel_index    (res.pixel_index),
  .res_filtered_value (res.filtered_value),
  .res_last_of_run    (res.last_of_run)
);
